[rtl/cct_pkg.sv]
// shared constants, codes and control structs of the contingency count table
`default_nettype none

package cct_pkg;

    localparam int MAX_CATEGORIES_DEF = 16;
    localparam int COUNT_WIDTH_DEF    = 32;

    localparam int OP_W        = 3;
    localparam int IDX_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int SUM_W       = 40;
    localparam int OUT_W       = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 5;
    localparam int DIM_MIN     = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // operation codes
    localparam logic [OP_W-1:0] OP_INC      = 3'd0;
    localparam logic [OP_W-1:0] OP_SET      = 3'd1;
    localparam logic [OP_W-1:0] OP_READ     = 3'd2;
    localparam logic [OP_W-1:0] OP_COLLAPSE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;
    localparam logic [OP_W-1:0] OP_EXTREMES = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SQUARE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_ROWS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COLS = 4'd1;

    typedef struct packed {
        logic capture;
        logic walk_start;
        logic walk_issue;
        logic inc_write;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] in_status;
        logic                sweep_busy;
        logic                walk_last;
        logic                out_free;
    } t_stat;

endpackage

`default_nettype wire

[rtl/cct_ctrl.sv]
// sequencing state machine of the contingency count table
`default_nettype none

module cct_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic [cct_pkg::OP_W-1:0] i_op,
    output logic                       o_in_ready,
    output cct_pkg::t_cmd              o_cmd,
    input  wire cct_pkg::t_stat        i_stat
);
    import cct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INC,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_stat.sweep_busy;
                if (i_in_valid && !i_stat.sweep_busy) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.in_status != ST_OK) begin
                        n_state = S_FINISH;
                    end else begin
                        case (i_op)
                            OP_INC: begin
                                n_state = S_INC;
                            end
                            OP_READ, OP_COLLAPSE, OP_EXTREMES: begin
                                o_cmd.walk_start = 1'b1;
                                n_state          = S_WALK;
                            end
                            default: begin
                                n_state = S_FINISH;
                            end
                        endcase
                    end
                end
            end
            S_INC: begin
                if (i_stat.out_free) begin
                    o_cmd.inc_write = 1'b1;
                    o_cmd.load_out  = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.walk_issue = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/cct_datapath.sv]
// count memory, configuration, table walk accumulators and result register
`default_nettype none

module cct_datapath #(
    parameter int MAX_CATEGORIES = cct_pkg::MAX_CATEGORIES_DEF,
    parameter int COUNT_WIDTH    = cct_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire cct_pkg::t_cmd                i_cmd,
    output cct_pkg::t_stat                    o_stat,
    input  wire logic [cct_pkg::OP_W-1:0]     i_op,
    input  wire logic [cct_pkg::IDX_W-1:0]    i_row,
    input  wire logic [cct_pkg::IDX_W-1:0]    i_col,
    input  wire logic [cct_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [cct_pkg::IDX_W-1:0]    i_category,
    input  wire logic                         i_cfg_valid,
    input  wire logic [cct_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [cct_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                              o_cfg_ready,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [cct_pkg::STATUS_W-1:0]      o_status,
    output logic [cct_pkg::OUT_W-1:0]         o_cell_count,
    output logic [cct_pkg::SUM_W-1:0]         o_row_sum,
    output logic [cct_pkg::SUM_W-1:0]         o_col_sum,
    output logic [cct_pkg::SUM_W-1:0]         o_grand_sum,
    output logic [cct_pkg::OUT_W-1:0]         o_hit_count,
    output logic [cct_pkg::SUM_W-1:0]         o_false_alarm_count,
    output logic [cct_pkg::SUM_W-1:0]         o_miss_count,
    output logic [cct_pkg::SUM_W-1:0]         o_correct_negative_count,
    output logic [cct_pkg::OUT_W-1:0]         o_largest_count,
    output logic [cct_pkg::OUT_W-1:0]         o_smallest_count
);
    import cct_pkg::*;

    localparam int CW    = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
    localparam int DW    = CW + 1;
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int CMPW  = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
    localparam int XW    = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
    localparam int SW    = ((COUNT_WIDTH > SUM_W) ? COUNT_WIDTH : SUM_W) + 1;
    localparam logic [COUNT_WIDTH-1:0] CELL_MAX = '1;

    function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_WIDTH-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        if (x > XW'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return x[OUT_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [COUNT_WIDTH-1:0] v);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(v);
        if (s > SW'(SUM_MAX)) begin
            return SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

    // configuration
    logic [DW-1:0]   r_num_rows;
    logic [DW-1:0]   r_num_cols;
    logic [CMPW-1:0] cfg_ext;
    logic [CMPW-1:0] cfg_dim;
    logic            cfg_hit;

    // count memory
    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic [AW-1:0]          rd_addr;
    logic                   we;
    logic [AW-1:0]          wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic                   r_sweep_busy;
    logic [AW-1:0]          r_sweep_addr;
    logic                   sweep_start;

    // captured word
    logic [OP_W-1:0]     r_op;
    logic [CMPW-1:0]     r_row;
    logic [CMPW-1:0]     r_col;
    logic [CMPW-1:0]     r_cat;
    logic [VALUE_W-1:0]  r_value;
    logic [STATUS_W-1:0] r_err;
    logic [CMPW-1:0]     row_ext;
    logic [CMPW-1:0]     col_ext;
    logic [CMPW-1:0]     cat_ext;
    logic [STATUS_W-1:0] in_status;

    // table walk
    logic [CW-1:0] r_wi;
    logic [CW-1:0] r_wj;
    logic [DW-1:0] rows_m1;
    logic [DW-1:0] cols_m1;
    logic          wj_end;
    logic          r_tag_valid;
    logic          r_tag_first;
    logic [CW-1:0] r_tag_i;
    logic [CW-1:0] r_tag_j;
    logic          tag_on_row;
    logic          tag_on_col;

    // accumulators
    logic [COUNT_WIDTH-1:0] r_acc_cell;
    logic [SUM_W-1:0]       r_acc_a;
    logic [SUM_W-1:0]       r_acc_b;
    logic [SUM_W-1:0]       r_acc_c;
    logic [COUNT_WIDTH-1:0] r_acc_hi;
    logic [COUNT_WIDTH-1:0] r_acc_lo;

    logic [COUNT_WIDTH-1:0] inc_val;
    logic [COUNT_WIDTH-1:0] set_val;
    logic [XW-1:0]          value_ext;
    logic                   r_out_valid;
    logic                   set_write;

    assign o_cfg_ready = 1'b1;

    assign cfg_ext = CMPW'(i_cfg_data);
    always_comb begin
        if (cfg_ext < CMPW'(DIM_MIN)) begin
            cfg_dim = CMPW'(DIM_MIN);
        end else if (cfg_ext > CMPW'(MAX_CATEGORIES)) begin
            cfg_dim = CMPW'(MAX_CATEGORIES);
        end else begin
            cfg_dim = cfg_ext;
        end
    end
    assign cfg_hit = i_cfg_valid &&
                     ((i_cfg_index == CFG_NUM_ROWS) || (i_cfg_index == CFG_NUM_COLS));

    // input checks
    assign row_ext = CMPW'(i_row);
    assign col_ext = CMPW'(i_col);
    assign cat_ext = CMPW'(i_category);

    always_comb begin
        case (i_op)
            OP_INC, OP_SET, OP_READ: begin
                in_status = ((row_ext < CMPW'(r_num_rows)) && (col_ext < CMPW'(r_num_cols)))
                          ? ST_OK : ST_RANGE;
            end
            OP_COLLAPSE: begin
                if (r_num_rows != r_num_cols) begin
                    in_status = ST_SQUARE;
                end else if (cat_ext < CMPW'(r_num_rows)) begin
                    in_status = ST_OK;
                end else begin
                    in_status = ST_RANGE;
                end
            end
            OP_CLEAR, OP_EXTREMES: begin
                in_status = ST_OK;
            end
            default: begin
                in_status = ST_RANGE;
            end
        endcase
    end

    assign rows_m1 = r_num_rows - DW'(1);
    assign cols_m1 = r_num_cols - DW'(1);
    assign wj_end  = (DW'(r_wj) == cols_m1);

    assign o_stat.in_status  = in_status;
    assign o_stat.sweep_busy = r_sweep_busy;
    assign o_stat.walk_last  = (DW'(r_wi) == rows_m1) && wj_end;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign sweep_start = cfg_hit ||
                         (i_cmd.capture && (i_op == OP_CLEAR) && (in_status == ST_OK));

    // memory ports
    always_comb begin
        if (i_cmd.walk_issue) begin
            rd_addr = {r_wi, r_wj};
        end else if (i_cmd.capture) begin
            rd_addr = {row_ext[CW-1:0], col_ext[CW-1:0]};
        end else begin
            rd_addr = {r_row[CW-1:0], r_col[CW-1:0]};
        end
    end

    assign inc_val   = (r_rdata != CELL_MAX) ? r_rdata + COUNT_WIDTH'(1) : r_rdata;
    assign value_ext = XW'(r_value);
    assign set_val   = (value_ext > XW'(CELL_MAX)) ? CELL_MAX : value_ext[COUNT_WIDTH-1:0];
    assign set_write = i_cmd.load_out && (r_op == OP_SET) && (r_err == ST_OK);

    always_comb begin
        we      = 1'b0;
        wr_addr = {r_row[CW-1:0], r_col[CW-1:0]};
        wr_data = '0;
        if (r_sweep_busy) begin
            we      = 1'b1;
            wr_addr = r_sweep_addr;
        end else if (i_cmd.inc_write) begin
            we      = 1'b1;
            wr_data = inc_val;
        end else if (set_write) begin
            we      = 1'b1;
            wr_data = set_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows   <= DW'(DIM_MIN);
            r_num_cols   <= DW'(DIM_MIN);
            r_sweep_busy <= 1'b1;
            r_sweep_addr <= '0;
            r_tag_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_NUM_ROWS)) begin
                r_num_rows <= cfg_dim[DW-1:0];
            end
            if (i_cfg_valid && (i_cfg_index == CFG_NUM_COLS)) begin
                r_num_cols <= cfg_dim[DW-1:0];
            end
            if (sweep_start) begin
                r_sweep_busy <= 1'b1;
                r_sweep_addr <= '0;
            end else if (r_sweep_busy) begin
                if (r_sweep_addr == AW'(DEPTH - 1)) begin
                    r_sweep_busy <= 1'b0;
                end
                r_sweep_addr <= r_sweep_addr + AW'(1);
            end
            r_tag_valid <= i_cmd.walk_issue;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // captured word and walk counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_row   <= row_ext;
            r_col   <= col_ext;
            r_cat   <= cat_ext;
            r_value <= i_value;
            r_err   <= in_status;
        end
        if (i_cmd.walk_start) begin
            r_wi <= '0;
            r_wj <= '0;
        end else if (i_cmd.walk_issue) begin
            if (wj_end) begin
                r_wj <= '0;
                r_wi <= r_wi + CW'(1);
            end else begin
                r_wj <= r_wj + CW'(1);
            end
        end
        r_tag_i     <= r_wi;
        r_tag_j     <= r_wj;
        r_tag_first <= (r_wi == '0) && (r_wj == '0);
    end

    // accumulate one cell per cycle behind the memory read
    always_comb begin
        if (r_op == OP_COLLAPSE) begin
            tag_on_row = (CMPW'(r_tag_i) == r_cat);
            tag_on_col = (CMPW'(r_tag_j) == r_cat);
        end else begin
            tag_on_row = (CMPW'(r_tag_i) == r_row);
            tag_on_col = (CMPW'(r_tag_j) == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_acc_cell <= '0;
            r_acc_a    <= '0;
            r_acc_b    <= '0;
            r_acc_c    <= '0;
            r_acc_hi   <= '0;
            r_acc_lo   <= '0;
        end else if (r_tag_valid) begin
            if (tag_on_row && tag_on_col) begin
                r_acc_cell <= r_rdata;
            end
            case (r_op)
                OP_READ: begin
                    if (tag_on_row) begin
                        r_acc_a <= sat_add(r_acc_a, r_rdata);
                    end
                    if (tag_on_col) begin
                        r_acc_b <= sat_add(r_acc_b, r_rdata);
                    end
                    r_acc_c <= sat_add(r_acc_c, r_rdata);
                end
                OP_COLLAPSE: begin
                    if (tag_on_row && !tag_on_col) begin
                        r_acc_a <= sat_add(r_acc_a, r_rdata);
                    end
                    if (tag_on_col && !tag_on_row) begin
                        r_acc_b <= sat_add(r_acc_b, r_rdata);
                    end
                    if (!tag_on_row && !tag_on_col) begin
                        r_acc_c <= sat_add(r_acc_c, r_rdata);
                    end
                end
                OP_EXTREMES: begin
                    if (r_tag_first || (r_rdata > r_acc_hi)) begin
                        r_acc_hi <= r_rdata;
                    end
                    if (r_tag_first || (r_rdata < r_acc_lo)) begin
                        r_acc_lo <= r_rdata;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status                 <= r_err;
            o_cell_count             <= '0;
            o_row_sum                <= '0;
            o_col_sum                <= '0;
            o_grand_sum              <= '0;
            o_hit_count              <= '0;
            o_false_alarm_count      <= '0;
            o_miss_count             <= '0;
            o_correct_negative_count <= '0;
            o_largest_count          <= '0;
            o_smallest_count         <= '0;
            if (r_err == ST_OK) begin
                case (r_op)
                    OP_INC: begin
                        o_cell_count <= clamp_out(inc_val);
                    end
                    OP_SET: begin
                        o_cell_count <= clamp_out(set_val);
                    end
                    OP_READ: begin
                        o_cell_count <= clamp_out(r_acc_cell);
                        o_row_sum    <= r_acc_a;
                        o_col_sum    <= r_acc_b;
                        o_grand_sum  <= r_acc_c;
                    end
                    OP_COLLAPSE: begin
                        o_hit_count              <= clamp_out(r_acc_cell);
                        o_false_alarm_count      <= r_acc_a;
                        o_miss_count             <= r_acc_b;
                        o_correct_negative_count <= r_acc_c;
                    end
                    OP_EXTREMES: begin
                        o_largest_count  <= clamp_out(r_acc_hi);
                        o_smallest_count <= clamp_out(r_acc_lo);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/contingency_count_table_top.sv]
// top level of the contingency count table
//
// The table lives in a two-port count memory with one write and one registered read per
// cycle. Increment reads the cell, then does a saturating write; set, clear and rejected words
// go to the finish state; read, collapse and extremes walk the cells in use one per cycle,
// then pass the drain and finish states. A new word is taken while the previous result waits
// in the output register. After reset, after a clear word and after a write to either register
// the memory, (2 ** clog2(MAX_CATEGORIES)) ** 2 cells, 256 at the default size, is swept to
// zero one cell per cycle; no word is taken in the sweep, register writes are always taken.
`default_nettype none

module contingency_count_table_top #(
    parameter int MAX_CATEGORIES = cct_pkg::MAX_CATEGORIES_DEF,
    parameter int COUNT_WIDTH    = cct_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [cct_pkg::OP_W-1:0]        i_op,
    input  wire logic [cct_pkg::IDX_W-1:0]       i_row,
    input  wire logic [cct_pkg::IDX_W-1:0]       i_col,
    input  wire logic [cct_pkg::VALUE_W-1:0]     i_value,
    input  wire logic [cct_pkg::IDX_W-1:0]       i_category,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cct_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [cct_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [cct_pkg::STATUS_W-1:0]         o_status,
    output logic [cct_pkg::OUT_W-1:0]            o_cell_count,
    output logic [cct_pkg::SUM_W-1:0]            o_row_sum,
    output logic [cct_pkg::SUM_W-1:0]            o_col_sum,
    output logic [cct_pkg::SUM_W-1:0]            o_grand_sum,
    output logic [cct_pkg::OUT_W-1:0]            o_hit_count,
    output logic [cct_pkg::SUM_W-1:0]            o_false_alarm_count,
    output logic [cct_pkg::SUM_W-1:0]            o_miss_count,
    output logic [cct_pkg::SUM_W-1:0]            o_correct_negative_count,
    output logic [cct_pkg::OUT_W-1:0]            o_largest_count,
    output logic [cct_pkg::OUT_W-1:0]            o_smallest_count
);
    import cct_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    cct_datapath #(
        .MAX_CATEGORIES (MAX_CATEGORIES),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_datapath (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (cmd),
        .o_stat                   (stat),
        .i_op                     (i_op),
        .i_row                    (i_row),
        .i_col                    (i_col),
        .i_value                  (i_value),
        .i_category               (i_category),
        .i_cfg_valid              (i_cfg_valid),
        .i_cfg_index              (i_cfg_index),
        .i_cfg_data               (i_cfg_data),
        .o_cfg_ready              (o_cfg_ready),
        .o_out_valid              (o_out_valid),
        .i_out_ready              (i_out_ready),
        .o_status                 (o_status),
        .o_cell_count             (o_cell_count),
        .o_row_sum                (o_row_sum),
        .o_col_sum                (o_col_sum),
        .o_grand_sum              (o_grand_sum),
        .o_hit_count              (o_hit_count),
        .o_false_alarm_count      (o_false_alarm_count),
        .o_miss_count             (o_miss_count),
        .o_correct_negative_count (o_correct_negative_count),
        .o_largest_count          (o_largest_count),
        .o_smallest_count         (o_smallest_count)
    );

endmodule

`default_nettype wire
